@@ hdl/hcc_pkg.sv @@
// ----------------------------------------------------------------------------
// hcc_pkg
// Shared constants, types and helpers for the Hamming chain ordering block.
// ----------------------------------------------------------------------------
package hcc_pkg;

  localparam int MAX_WORDS  = 64;
  localparam int WORD_BYTES = 64;
  localparam int NCELLS     = 8;

  localparam int WIDX_W = $clog2(MAX_WORDS);
  localparam int CNT_W  = $clog2(MAX_WORDS + 1);
  localparam int BI_W   = $clog2(WORD_BYTES);
  localparam int BP_W   = $clog2(WORD_BYTES + 1);
  localparam int ADDR_W = $clog2(MAX_WORDS * WORD_BYTES);
  localparam int DIST_W = $clog2(8 * WORD_BYTES + 1);
  localparam int PC_W   = $clog2(NCELLS + 1);
  localparam int OUT_W  = 6;
  localparam int OD_W   = 10;
  localparam int DIST_SAT = 1023;

  typedef struct packed {
    logic            valid;
    logic [7:0]      bits;
    logic [PC_W-1:0] count;
  } pop_t;

  function automatic logic [ADDR_W-1:0] store_addr(input logic [WIDX_W-1:0] w,
                                                   input logic [BI_W-1:0] b);
    return ADDR_W'(w) * ADDR_W'(WORD_BYTES) + ADDR_W'(b);
  endfunction

  function automatic logic [OD_W-1:0] dist_sat(input logic [DIST_W-1:0] d);
    logic [DIST_W+OD_W-1:0] w;
    w = (DIST_W + OD_W)'(d);
    if (w > (DIST_W + OD_W)'(DIST_SAT)) return OD_W'(DIST_SAT);
    return w[OD_W-1:0];
  endfunction

endpackage

@@ hdl/hcc_if.sv @@
// ----------------------------------------------------------------------------
// hcc interfaces
// Valid/ready channels for loaded bytes and ordered chain results.
// ----------------------------------------------------------------------------
interface hcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       word_end;
  logic       list_end;
  modport source (output valid, char_code, word_end, list_end, input ready);
  modport sink (input valid, char_code, word_end, list_end, output ready);
endinterface

interface hcc_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] position;
  logic [5:0] word_index;
  logic [9:0] bit_distance;
  logic       overflow;
  logic       last;
  modport source (output valid, position, word_index, bit_distance, overflow, last,
                  input ready);
  modport sink (input valid, position, word_index, bit_distance, overflow, last,
                output ready);
endinterface

@@ hdl/greedy_hamming_chain_order.sv @@
// loading: each short word is zero-filled up to WORD_BYTES bytes before the next is taken
// ordering: about n*n/2 distances, each summed byte by byte through the byte-serial popcount
// chain from the single word store read pair; emit adds a distance to each non-head result
// throughput: one byte per cycle during load, none while padding, ordering or emitting
// reset: synchronous, clears word/byte counters and flags; store contents rewritten per word
module greedy_hamming_chain_order import hcc_pkg::*; (
  input logic     clk,
  input logic     rst,
  hcc_in_if.sink  in_ch,
  hcc_out_if.source out_ch
);

  typedef enum logic [3:0] {
    S_LOAD, S_PAD, S_I_CHECK, S_I_FETCH, S_I_LATCH, S_J_CHECK, S_J_FETCH, S_J_LATCH,
    S_DIST, S_DRAIN, S_E_FETCH, S_E_LATCH, S_E_OUT
  } state_t;

  typedef enum logic [1:0] {DM_BEST, DM_CAND, DM_EMIT} mode_t;

  state_t state;
  mode_t  mode;

  logic [CNT_W-1:0]  word_count, i, j, k;
  logic [BP_W-1:0]   byte_position, pad_b;
  logic [WIDX_W-1:0] pad_w, wa, cur, wj, da, db, ow;
  logic              overflow_flag, pad_list_end, rd_v;
  logic [BI_W-1:0]   bc;
  logic [DIST_W-1:0] acc, best;
  logic [OD_W-1:0]   od;

  logic              st_we;
  logic [ADDR_W-1:0] st_waddr, st_ra0, st_ra1;
  logic [7:0]        st_wdata, st_rd0, st_rd1;
  logic              or_we;
  logic [WIDX_W-1:0] or_waddr, or_wdata, or_ra0, or_ra1, or_rd0, or_rd1;

  pop_t pin, pout;
  logic chain_busy, dist_done, in_acc, out_acc, byte_ok, is_end;
  logic [CNT_W:0] ip1, ip2, km1;

  hcc_ram #(.WIDTH(8), .DEPTH(MAX_WORDS * WORD_BYTES)) u_store (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr0(st_ra0), .raddr1(st_ra1), .rdata0(st_rd0), .rdata1(st_rd1)
  );

  hcc_ram #(.WIDTH(WIDX_W), .DEPTH(MAX_WORDS)) u_order (
    .clk(clk), .we(or_we), .waddr(or_waddr), .wdata(or_wdata),
    .raddr0(or_ra0), .raddr1(or_ra1), .rdata0(or_rd0), .rdata1(or_rd1)
  );

  assign pin.valid = rd_v;
  assign pin.bits  = st_rd0 ^ st_rd1;
  assign pin.count = '0;

  hcc_chain u_chain (.clk(clk), .rst(rst), .din(pin), .dout(pout), .busy(chain_busy));

  assign in_ch.ready = (state == S_LOAD);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_acc     = out_ch.valid && out_ch.ready;
  assign byte_ok     = (word_count < CNT_W'(MAX_WORDS)) &&
                       (byte_position < BP_W'(WORD_BYTES));
  assign is_end      = in_ch.word_end || in_ch.list_end;
  assign dist_done   = (state == S_DRAIN) && !rd_v && !chain_busy;
  assign ip1         = (CNT_W + 1)'(i) + 1'b1;
  assign ip2         = (CNT_W + 1)'(i) + 2'd2;
  assign km1         = (CNT_W + 1)'(k) - 1'b1;

  always_comb begin
    st_we    = 1'b0;
    st_waddr = store_addr(word_count[WIDX_W-1:0], byte_position[BI_W-1:0]);
    st_wdata = in_ch.char_code;
    if (state == S_LOAD) begin
      st_we = in_acc && byte_ok;
    end else if (state == S_PAD) begin
      st_we    = 1'b1;
      st_waddr = store_addr(pad_w, pad_b[BI_W-1:0]);
      st_wdata = '0;
    end
    st_ra0 = store_addr(da, bc);
    st_ra1 = store_addr(db, bc);

    or_we    = 1'b0;
    or_waddr = word_count[WIDX_W-1:0];
    or_wdata = word_count[WIDX_W-1:0];
    if (state == S_LOAD) begin
      or_we = in_acc && is_end && (word_count < CNT_W'(MAX_WORDS));
    end else if (state == S_J_CHECK && j >= word_count) begin
      or_we    = 1'b1;
      or_waddr = ip1[WIDX_W-1:0];
      or_wdata = cur;
    end else if (dist_done && mode == DM_CAND && acc < best) begin
      or_we    = 1'b1;
      or_waddr = j[WIDX_W-1:0];
      or_wdata = cur;
    end

    or_ra0 = '0;
    or_ra1 = '0;
    unique case (state)
      S_I_FETCH: begin
        or_ra0 = i[WIDX_W-1:0];
        or_ra1 = ip1[WIDX_W-1:0];
      end
      S_J_FETCH: or_ra0 = j[WIDX_W-1:0];
      S_E_FETCH: begin
        or_ra0 = km1[WIDX_W-1:0];
        or_ra1 = k[WIDX_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      mode          <= DM_BEST;
      word_count    <= '0;
      byte_position <= '0;
      overflow_flag <= 1'b0;
      rd_v          <= 1'b0;
      out_ch.valid  <= 1'b0;
    end else begin
      rd_v <= (state == S_DIST);
      if (pout.valid) acc <= acc + DIST_W'(pout.count);
      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (byte_ok) byte_position <= byte_position + 1'b1;
            else overflow_flag <= 1'b1;
            if (is_end) begin
              byte_position <= '0;
              pad_list_end  <= in_ch.list_end;
              pad_w         <= word_count[WIDX_W-1:0];
              pad_b         <= byte_ok ? byte_position + 1'b1 : byte_position;
              if (word_count < CNT_W'(MAX_WORDS)) begin
                word_count <= word_count + 1'b1;
                if (byte_position + 1'b1 < BP_W'(WORD_BYTES)) state <= S_PAD;
                else if (in_ch.list_end) state <= S_I_CHECK;
              end else begin
                overflow_flag <= 1'b1;
                if (in_ch.list_end) state <= S_I_CHECK;
              end
              i <= '0;
            end
          end
        end
        S_PAD: begin
          pad_b <= pad_b + 1'b1;
          if (pad_b == BP_W'(WORD_BYTES - 1)) state <= pad_list_end ? S_I_CHECK : S_LOAD;
        end
        S_I_CHECK: begin
          if (ip2 < (CNT_W + 1)'(word_count)) state <= S_I_FETCH;
          else begin
            k     <= '0;
            state <= S_E_FETCH;
          end
        end
        S_I_FETCH: state <= S_I_LATCH;
        S_I_LATCH: begin
          wa    <= or_rd0;
          cur   <= or_rd1;
          da    <= or_rd0;
          db    <= or_rd1;
          bc    <= '0;
          acc   <= '0;
          mode  <= DM_BEST;
          state <= S_DIST;
        end
        S_J_CHECK: begin
          if (j < word_count) state <= S_J_FETCH;
          else begin
            i     <= i + 1'b1;
            state <= S_I_CHECK;
          end
        end
        S_J_FETCH: state <= S_J_LATCH;
        S_J_LATCH: begin
          wj    <= or_rd0;
          da    <= wa;
          db    <= or_rd0;
          bc    <= '0;
          acc   <= '0;
          mode  <= DM_CAND;
          state <= S_DIST;
        end
        S_DIST: begin
          bc <= bc + 1'b1;
          if (bc == BI_W'(WORD_BYTES - 1)) state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (dist_done) begin
            unique case (mode)
              DM_BEST: begin
                best  <= acc;
                j     <= ip2[CNT_W-1:0];
                state <= S_J_CHECK;
              end
              DM_CAND: begin
                if (acc < best) begin
                  cur  <= wj;
                  best <= acc;
                end
                j     <= j + 1'b1;
                state <= S_J_CHECK;
              end
              default: begin
                od    <= dist_sat(acc);
                state <= S_E_OUT;
              end
            endcase
          end
        end
        S_E_FETCH: state <= S_E_LATCH;
        S_E_LATCH: begin
          ow <= or_rd1;
          if (k == '0) begin
            od    <= '0;
            state <= S_E_OUT;
          end else begin
            da    <= or_rd0;
            db    <= or_rd1;
            bc    <= '0;
            acc   <= '0;
            mode  <= DM_EMIT;
            state <= S_DIST;
          end
        end
        S_E_OUT: begin
          if (out_acc) begin
            if (k + 1'b1 == word_count) begin
              word_count    <= '0;
              byte_position <= '0;
              overflow_flag <= 1'b0;
              state         <= S_LOAD;
            end else begin
              k     <= k + 1'b1;
              state <= S_E_FETCH;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
      out_ch.valid <= (state == S_E_OUT) ? !out_acc :
                      ((state == S_E_LATCH && k == '0) ||
                       (dist_done && mode == DM_EMIT));
    end
  end

  assign out_ch.position     = OUT_W'(k);
  assign out_ch.word_index   = OUT_W'(ow);
  assign out_ch.bit_distance = od;
  assign out_ch.overflow     = overflow_flag;
  assign out_ch.last         = (k + 1'b1 == word_count);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !out_ch.valid) else $error("load and emit overlap");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    word_count <= CNT_W'(MAX_WORDS)) else $error("word count past capacity");

  a_first_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.position == '0) |-> out_ch.bit_distance == '0)
    else $error("nonzero distance at chain head");

endmodule

@@ hdl/hcc_ram.sv @@
// ----------------------------------------------------------------------------
// hcc_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module hcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

@@ hdl/hcc_cell.sv @@
// ----------------------------------------------------------------------------
// hcc_cell
// One popcount cell: adds the low bit and hands the shifted byte onward.
// ----------------------------------------------------------------------------
module hcc_cell import hcc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  pop_t din,
  output pop_t dout
);

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.bits  <= din.bits >> 1;
    dout.count <= din.count + PC_W'(din.bits[0]);
  end

endmodule

@@ hdl/hcc_chain.sv @@
// ----------------------------------------------------------------------------
// hcc_chain
// Row of popcount cells, one byte enters per cycle.
// ----------------------------------------------------------------------------
module hcc_chain import hcc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  pop_t din,
  output pop_t dout,
  output logic busy
);

  pop_t             stage [NCELLS+1];
  logic [NCELLS-1:0] vld;

  assign stage[0] = din;

  for (genvar c = 0; c < NCELLS; c++) begin : g_cell
    hcc_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (stage[c]),
      .dout (stage[c+1])
    );
    assign vld[c] = stage[c+1].valid;
  end

  assign dout = stage[NCELLS];
  assign busy = |vld;

endmodule
